/* design/tsq_pkg.sv */
package tsq_pkg;

    // Field and datapath widths.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int WIDTH_BITS = 9;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int Q_BITS     = 2 * FRAC_BITS + 1;
    localparam int ROOT_BITS  = FRAC_BITS + 1;
    localparam int FIX_BITS   = COORD_BITS + FRAC_BITS + 2;
    localparam int OFF_BITS   = WIDTH_BITS + ROOT_BITS;
    localparam int SHIFT      = FRAC_BITS + 1;

    // Pipeline depths.
    localparam int DIV_LAT   = Q_BITS;
    localparam int SQRT_LAT  = ROOT_BITS;
    localparam int SIDE_LEN  = 3 + DIV_LAT + SQRT_LAT + 1;
    localparam int VALID_LEN = SIDE_LEN + 2;

    // Segment kind codes.
    localparam logic [1:0] KIND_EQ_X = 2'd0;
    localparam logic [1:0] KIND_EQ_Y = 2'd1;
    localparam logic [1:0] KIND_DIAG = 2'd2;

    // Register map.
    localparam logic REG_BAND_WIDTH = 1'b0;
    localparam logic [WIDTH_BITS-1:0] BAND_WIDTH_RESET = 9'd16;

    // Segment data that travels beside the divide and root pipelines.
    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_BITS-1:0] p1x;
        logic [COORD_BITS-1:0] p1y;
        logic [COORD_BITS-1:0] p2x;
        logic [COORD_BITS-1:0] p2y;
        logic                  dy_neg;
    } side_t;

endpackage

/* design/tsq_frac_div.sv */
module tsq_frac_div
    import tsq_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic [SQ_BITS-1:0] num,
    input  logic [SQ_BITS-1:0] den,
    output logic [Q_BITS-1:0]  quot
);

    logic [SQ_BITS-1:0] rem_reg [DIV_LAT];
    logic [SQ_BITS-1:0] den_reg [DIV_LAT];
    logic [Q_BITS-1:0]  q_reg   [DIV_LAT];

    // First stage takes the integer part, which is one only when num equals den.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0] <= den;
            if (num == den)
            begin
                rem_reg[0] <= '0;
                q_reg[0]   <= Q_BITS'(1);
            end
            else
            begin
                rem_reg[0] <= num;
                q_reg[0]   <= '0;
            end
        end
    end

    // One restoring quotient bit per stage.
    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_step
        logic [SQ_BITS:0]   rem_dbl;
        logic               ge;
        logic [SQ_BITS:0]   rem_sub;

        assign rem_dbl = {rem_reg[k-1], 1'b0};
        assign ge      = rem_dbl >= {1'b0, den_reg[k-1]};
        assign rem_sub = rem_dbl - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= ge ? rem_sub[SQ_BITS-1:0] : rem_dbl[SQ_BITS-1:0];
                q_reg[k]   <= {q_reg[k-1][Q_BITS-2:0], ge};
            end
        end
    end

    assign quot = q_reg[DIV_LAT-1];

endmodule

/* design/tsq_isqrt.sv */
module tsq_isqrt
    import tsq_pkg::*;
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [Q_BITS-1:0]    val,
    output logic [ROOT_BITS-1:0] root
);

    localparam int X_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 3;

    logic [X_BITS-1:0]    x_reg    [SQRT_LAT];
    logic [REM_BITS-1:0]  rem_reg  [SQRT_LAT];
    logic [ROOT_BITS-1:0] root_reg [SQRT_LAT];

    // One root bit per stage, two radicand bits consumed each time.
    for (genvar k = 0; k < SQRT_LAT; k++)
    begin : g_step
        logic [X_BITS-1:0]    x_prev;
        logic [REM_BITS-1:0]  rem_prev;
        logic [ROOT_BITS-1:0] root_prev;
        logic [REM_BITS-1:0]  rem_sh;
        logic [REM_BITS-1:0]  trial;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign x_prev    = X_BITS'(val);
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_next
            assign x_prev    = x_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        assign rem_sh = {rem_prev[REM_BITS-3:0], x_prev[X_BITS-1 -: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]    <= {x_prev[X_BITS-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_prev[ROOT_BITS-2:0], ge};
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

/* design/thick_segment_to_quad.sv */
// Band corners for one line segment per transaction. The block is a fully
// pipelined setup engine that accepts a segment in every cycle while in_stall is
// low; the depth is set by the bit-per-stage fraction divider (33 stages) and
// the bit-per-stage square root (17 stages) that form the perpendicular
// direction. in_stall rises only while a finished result is held at the output
// under out_stall. band_width is written over the APB port at address 0 and
// should be changed only while no segment is in flight.
module thick_segment_to_quad
    import tsq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   seg_kind,
    output logic signed [OUT_BITS-1:0]   ul_x,
    output logic signed [OUT_BITS-1:0]   ul_y,
    output logic signed [OUT_BITS-1:0]   ur_x,
    output logic signed [OUT_BITS-1:0]   ur_y,
    output logic signed [OUT_BITS-1:0]   ll_x,
    output logic signed [OUT_BITS-1:0]   ll_y,
    output logic signed [OUT_BITS-1:0]   lr_x,
    output logic signed [OUT_BITS-1:0]   lr_y
);

    logic [WIDTH_BITS-1:0] band_width_reg;
    logic                  valid_reg [VALID_LEN];
    logic                  adv;

    side_t                 side_reg [SIDE_LEN];
    logic [COORD_BITS-1:0] adx_reg;
    logic [COORD_BITS-1:0] ady_reg;
    logic [SQ_BITS-1:0]    adx2_b_reg;
    logic [SQ_BITS-1:0]    ady2_b_reg;
    logic [SQ_BITS-1:0]    adx2_c_reg;
    logic [SQ_BITS-1:0]    ady2_c_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic [Q_BITS-1:0]     qr;
    logic [Q_BITS-1:0]     qs;
    logic [ROOT_BITS-1:0]  r_root;
    logic [ROOT_BITS-1:0]  s_root;
    logic [OFF_BITS-1:0]   ddx_reg;
    logic [OFF_BITS-1:0]   dys_reg;

    logic [FIX_BITS-1:0]   corner_next [8];
    logic [FIX_BITS-1:0]   corner_reg  [8];
    logic [1:0]            kind_s_reg;
    logic [1:0]            kind_o_reg;
    logic [OUT_BITS-1:0]   out_reg [8];

    side_t                 side_next;
    logic                  swap;
    logic [COORD_BITS:0]   dx_full;
    logic [COORD_BITS:0]   dy_full;
    logic [COORD_BITS:0]   dy_abs;

    // The whole pipeline moves unless a result sits unclaimed at the output.
    assign adv      = !valid_reg[VALID_LEN-1] || !out_stall;
    assign in_stall = !adv;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BAND_WIDTH) ? 32'(band_width_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_width_reg <= BAND_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_BAND_WIDTH)
        begin
            band_width_reg <= pwdata[WIDTH_BITS-1:0];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VALID_LEN; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < VALID_LEN; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Classify and order the endpoints.
    always_comb
    begin
        if (start_x == end_x)
        begin
            side_next.kind = KIND_EQ_X;
            swap           = start_y > end_y;
        end
        else
        begin
            side_next.kind = (start_y == end_y) ? KIND_EQ_Y : KIND_DIAG;
            swap           = start_x > end_x;
        end
        side_next.p1x = swap ? end_x : start_x;
        side_next.p1y = swap ? end_y : start_y;
        side_next.p2x = swap ? start_x : end_x;
        side_next.p2y = swap ? start_y : end_y;
        dx_full = {side_next.p2x[COORD_BITS-1], side_next.p2x}
                - {side_next.p1x[COORD_BITS-1], side_next.p1x};
        dy_full = {side_next.p2y[COORD_BITS-1], side_next.p2y}
                - {side_next.p1y[COORD_BITS-1], side_next.p1y};
        side_next.dy_neg = dy_full[COORD_BITS];
        dy_abs = dy_full[COORD_BITS] ? -dy_full : dy_full;
    end

    // Stages A to C: deltas, squares, squared length.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            adx_reg     <= dx_full[COORD_BITS-1:0];
            ady_reg     <= dy_abs[COORD_BITS-1:0];
            adx2_b_reg  <= SQ_BITS'(adx_reg * adx_reg);
            ady2_b_reg  <= SQ_BITS'(ady_reg * ady_reg);
            adx2_c_reg  <= adx2_b_reg;
            ady2_c_reg  <= ady2_b_reg;
            sq_reg      <= adx2_b_reg + ady2_b_reg;
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Squared direction cosines, then their roots.
    tsq_frac_div u_div_r (.clk(clk), .adv(adv), .num(ady2_c_reg), .den(sq_reg), .quot(qr));
    tsq_frac_div u_div_s (.clk(clk), .adv(adv), .num(adx2_c_reg), .den(sq_reg), .quot(qs));
    tsq_isqrt    u_sqrt_r (.clk(clk), .adv(adv), .val(qr), .root(r_root));
    tsq_isqrt    u_sqrt_s (.clk(clk), .adv(adv), .val(qs), .root(s_root));

    // Scale by the band width; the half of the half-width is in the extra
    // fraction bit.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ddx_reg <= OFF_BITS'(band_width_reg) * OFF_BITS'(r_root);
            dys_reg <= OFF_BITS'(band_width_reg) * OFF_BITS'(s_root);
        end
    end

    // Corner sums in fixed point with SHIFT fraction bits.
    always_comb
    begin
        side_t               sd;
        logic [FIX_BITS-1:0] p1x_f;
        logic [FIX_BITS-1:0] p1y_f;
        logic [FIX_BITS-1:0] p2x_f;
        logic [FIX_BITS-1:0] p2y_f;
        logic [FIX_BITS-1:0] h_f;
        logic [FIX_BITS-1:0] offx;
        logic [FIX_BITS-1:0] offy;
        logic                pos;

        sd    = side_reg[SIDE_LEN-1];
        p1x_f = FIX_BITS'($signed(sd.p1x)) << SHIFT;
        p1y_f = FIX_BITS'($signed(sd.p1y)) << SHIFT;
        p2x_f = FIX_BITS'($signed(sd.p2x)) << SHIFT;
        p2y_f = FIX_BITS'($signed(sd.p2y)) << SHIFT;
        h_f   = FIX_BITS'(band_width_reg >> 1) << SHIFT;
        offx  = FIX_BITS'(ddx_reg);
        offy  = sd.dy_neg ? FIX_BITS'(dys_reg) : -FIX_BITS'(dys_reg);
        pos   = sd.dy_neg && (dys_reg != '0);

        case (sd.kind)
            KIND_EQ_X:
            begin
                corner_next[0] = p1x_f - h_f;  corner_next[1] = p1y_f;
                corner_next[2] = p1x_f + h_f;  corner_next[3] = p1y_f;
                corner_next[4] = p2x_f - h_f;  corner_next[5] = p2y_f;
                corner_next[6] = p2x_f + h_f;  corner_next[7] = p2y_f;
            end
            KIND_EQ_Y:
            begin
                corner_next[0] = p1x_f;  corner_next[1] = p1y_f - h_f;
                corner_next[2] = p2x_f;  corner_next[3] = p2y_f - h_f;
                corner_next[4] = p1x_f;  corner_next[5] = p1y_f + h_f;
                corner_next[6] = p2x_f;  corner_next[7] = p2y_f + h_f;
            end
            default:
            begin
                if (pos)
                begin
                    corner_next[0] = p1x_f - offx;  corner_next[1] = p1y_f - offy;
                    corner_next[4] = p1x_f + offx;  corner_next[5] = p1y_f + offy;
                    corner_next[2] = p2x_f - offx;  corner_next[3] = p2y_f - offy;
                    corner_next[6] = p2x_f + offx;  corner_next[7] = p2y_f + offy;
                end
                else
                begin
                    corner_next[4] = p1x_f - offx;  corner_next[5] = p1y_f - offy;
                    corner_next[0] = p1x_f + offx;  corner_next[1] = p1y_f + offy;
                    corner_next[2] = p2x_f + offx;  corner_next[3] = p2y_f + offy;
                    corner_next[6] = p2x_f - offx;  corner_next[7] = p2y_f - offy;
                end
            end
        endcase
    end

    // Round half away from zero and wrap to the output width.
    function automatic logic [OUT_BITS-1:0] round_corner(input logic [FIX_BITS-1:0] v);
        logic [FIX_BITS-1:0] mag;
        logic [FIX_BITS-1:0] q;
        mag = v[FIX_BITS-1] ? -v : v;
        q   = (mag + (FIX_BITS'(1) << FRAC_BITS)) >> SHIFT;
        q   = v[FIX_BITS-1] ? -q : q;
        return q[OUT_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_s_reg <= side_reg[SIDE_LEN-1].kind;
            kind_o_reg <= kind_s_reg;
            for (int i = 0; i < 8; i++)
            begin
                corner_reg[i] <= corner_next[i];
                out_reg[i]    <= round_corner(corner_reg[i]);
            end
        end
    end

    assign out_valid = valid_reg[VALID_LEN-1];
    assign seg_kind  = kind_o_reg;
    assign ul_x      = out_reg[0];
    assign ul_y      = out_reg[1];
    assign ur_x      = out_reg[2];
    assign ur_y      = out_reg[3];
    assign ll_x      = out_reg[4];
    assign ll_y      = out_reg[5];
    assign lr_x      = out_reg[6];
    assign lr_y      = out_reg[7];

endmodule
